[design/assert_macros.svh]
// Assertion macros shared by the sigmoid core.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define SGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgm assertion failed");

// Condition that must never hold outside reset.
`define SGM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sgm forbidden condition seen");

`endif

[design/sgm_pkg.sv]
// Package for the quantized int8 sigmoid core: payload types, register codes,
// fixed-point constants and pipeline sizing. No dependencies.
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int IN_SCALE_W  = 24;
  localparam int OUT_SCALE_W = 31;
  localparam int CFG_DATA_W  = 31;
  localparam int E_W         = 17;

  localparam logic [E_W-1:0] Q16_ONE     = 17'd65536;
  localparam logic [16:0]    INV_LN2_Q16 = 17'd94548;
  localparam logic [15:0]    C1_Q16      = 16'd45426;
  localparam logic [13:0]    C2_Q16      = 14'd15743;
  localparam logic [11:0]    C3_Q16      = 12'd3638;
  localparam logic [15:0]    SHIFT_LIMIT = 16'd31;

  localparam int EXP_STAGES = 7;
  localparam int OUT_STAGES = 3;

  localparam int DIV_Q_W     = 18;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = DIV_Q_W / DIV_STEPS;
  localparam int DIV_REM_W   = 36;
  localparam int DIV_DEN_W   = 18;
  localparam logic [DIV_REM_W-1:0] DIV_NUM_POS = DIV_REM_W'(1) << 32;

  typedef enum logic [1:0] {
    REG_IN_SCALE      = 2'd0,
    REG_INV_OUT_SCALE = 2'd1,
    REG_CLAMP_LOW     = 2'd2,
    REG_CLAMP_HIGH    = 2'd3
  } sgm_reg_e;

  typedef struct packed {
    logic signed [7:0] sample;
    logic              last_in;
  } sgm_in_t;

  typedef struct packed {
    logic signed [7:0] activation;
    logic              last_out;
  } sgm_out_t;

  typedef struct packed {
    logic last;
    logic neg;
  } sgm_tag_t;

  typedef struct packed {
    logic           valid;
    sgm_tag_t       tag;
    logic [E_W-1:0] e;
  } sgm_exp_t;

  typedef struct packed {
    logic           valid;
    sgm_tag_t       tag;
    logic [E_W-1:0] q;
  } sgm_quo_t;

endpackage

[design/sgm_exp.sv]
// Seven-stage pipeline: input scaling and e^-|z| in Q16 via 2^(-k-f) cubic.
// Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_exp import sgm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  sgm_in_t               in_data_i,
  input  logic [IN_SCALE_W-1:0] in_scale_i,
  output sgm_exp_t              exp_o
);

  logic [EXP_STAGES-1:0] vld_q;
  sgm_tag_t              tag_q [EXP_STAGES];
  sgm_tag_t              tag_d;

  // stage 1: |x| * scale
  logic [7:0]  mag;
  logic [31:0] s1_prod;
  logic [30:0] s1_a_q;

  // stage 2: times 1/ln2, split
  logic [47:0] s2_prod;
  logic [31:0] s2_t;
  logic [15:0] s2_f_q;
  logic [4:0]  s2_k_q;
  logic        s2_big_q;

  // stage 3
  logic [31:0] s3_ff, s3_m1;
  logic [15:0] s3_f_q, s3_f2_q, s3_c1_q;
  logic [4:0]  s3_k_q;
  logic        s3_big_q;

  // stage 4
  logic [31:0] s4_m3, s4_m2;
  logic [15:0] s4_f3_q, s4_c1_q, s4_c2_q;
  logic [4:0]  s4_k_q;
  logic        s4_big_q;

  // stage 5
  logic [31:0] s5_m;
  logic [15:0] s5_c1_q, s5_c2_q, s5_c3_q;
  logic [4:0]  s5_k_q;
  logic        s5_big_q;

  // stage 6: polynomial sum
  logic [18:0] s6_p;
  logic [17:0] s6_p_q;
  logic [4:0]  s6_k_q;
  logic        s6_big_q;

  // stage 7: rounded shift
  logic [30:0]    s7_rnd, s7_sum, s7_sh;
  logic [E_W-1:0] s7_e_d, s7_e_q;

  assign mag     = in_data_i.sample[7] ? (~in_data_i.sample + 8'd1) : in_data_i.sample;
  assign s1_prod = 32'(mag) * 32'(in_scale_i);
  assign tag_d   = '{last: in_data_i.last_in,
                     neg:  in_data_i.sample[7] & (in_scale_i != '0)};

  assign s2_prod = 48'(s1_a_q) * 48'(INV_LN2_Q16);
  assign s2_t    = s2_prod[47:16];

  assign s3_ff = 32'(s2_f_q) * 32'(s2_f_q);
  assign s3_m1 = 32'(s2_f_q) * 32'(C1_Q16);

  assign s4_m3 = 32'(s3_f2_q) * 32'(s3_f_q);
  assign s4_m2 = 32'(s3_f2_q) * 32'(C2_Q16);

  assign s5_m = 32'(s4_f3_q) * 32'(C3_Q16);

  assign s6_p = 19'(Q16_ONE) - 19'(s5_c1_q) + 19'(s5_c2_q) - 19'(s5_c3_q);

  always_comb begin
    s7_rnd = (s6_k_q == '0) ? '0 : (31'(1) << (s6_k_q - 5'd1));
    s7_sum = 31'(s6_p_q) + s7_rnd;
    s7_sh  = s7_sum >> s6_k_q;
    if (s6_big_q) begin
      s7_e_d = '0;
    end else if (s7_sh > 31'(Q16_ONE)) begin
      s7_e_d = Q16_ONE;
    end else begin
      s7_e_d = s7_sh[E_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[EXP_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_d;
      for (int i = 1; i < EXP_STAGES; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      s1_a_q   <= s1_prod[30:0];
      s2_f_q   <= s2_t[15:0];
      s2_k_q   <= s2_t[20:16];
      s2_big_q <= (s2_t[31:16] >= SHIFT_LIMIT);
      s3_f_q   <= s2_f_q;
      s3_f2_q  <= s3_ff[31:16];
      s3_c1_q  <= s3_m1[31:16];
      s3_k_q   <= s2_k_q;
      s3_big_q <= s2_big_q;
      s4_f3_q  <= s4_m3[31:16];
      s4_c1_q  <= s3_c1_q;
      s4_c2_q  <= s4_m2[31:16];
      s4_k_q   <= s3_k_q;
      s4_big_q <= s3_big_q;
      s5_c1_q  <= s4_c1_q;
      s5_c2_q  <= s4_c2_q;
      s5_c3_q  <= s5_m[31:16];
      s5_k_q   <= s4_k_q;
      s5_big_q <= s4_big_q;
      s6_p_q   <= s6_p[18] ? '0 : s6_p[17:0];
      s6_k_q   <= s5_k_q;
      s6_big_q <= s5_big_q;
      s7_e_q   <= s7_e_d;
    end
  end

  assign exp_o = '{valid: vld_q[EXP_STAGES-1], tag: tag_q[EXP_STAGES-1], e: s7_e_q};

endmodule

[design/sgm_div.sv]
// Pipelined restoring divider forming the Q16 logistic, two quotient bits per stage.
// Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_div import sgm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  sgm_exp_t exp_i,
  output sgm_quo_t quo_o
);

  logic [DIV_STAGES:0]   vld_q;
  sgm_tag_t              tag_q [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0]  den_q [DIV_STAGES+1];
  logic [DIV_REM_W-1:0]  rem_q [DIV_STAGES+1];
  logic [DIV_Q_W-1:0]    quo_q [DIV_STAGES+1];
  logic [DIV_REM_W-1:0]  rem_d [DIV_STAGES+1];
  logic [DIV_Q_W-1:0]    quo_d [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0]  den_d;

  always_comb begin
    logic [DIV_REM_W-1:0] r, dsh;
    logic [DIV_Q_W-1:0]   q;
    logic                 take;
    den_d    = DIV_DEN_W'(Q16_ONE) + DIV_DEN_W'(exp_i.e);
    rem_d[0] = exp_i.tag.neg ? (DIV_REM_W'(exp_i.e) << 16) : DIV_NUM_POS;
    quo_d[0] = '0;
    for (int g = 0; g < DIV_STAGES; g++) begin
      r = rem_q[g];
      q = quo_q[g];
      for (int s = 0; s < DIV_STEPS; s++) begin
        dsh  = DIV_REM_W'(den_q[g]) << (DIV_Q_W - 1 - g * DIV_STEPS - s);
        take = (r >= dsh);
        if (take) begin
          r = r - dsh;
        end
        q = {q[DIV_Q_W-2:0], take};
      end
      rem_d[g+1] = r;
      quo_d[g+1] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-1:0], exp_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= exp_i.tag;
      den_q[0] <= den_d;
      for (int g = 1; g <= DIV_STAGES; g++) begin
        tag_q[g] <= tag_q[g-1];
        den_q[g] <= den_q[g-1];
      end
      for (int g = 0; g <= DIV_STAGES; g++) begin
        rem_q[g] <= rem_d[g];
        quo_q[g] <= quo_d[g];
      end
    end
  end

  assign quo_o = '{valid: vld_q[DIV_STAGES], tag: tag_q[DIV_STAGES],
                   q: quo_q[DIV_STAGES][E_W-1:0]};

endmodule

[design/sgm_out.sv]
// Output stages: scale by inverse output scale, round at bit 32, clamp.
// Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_out import sgm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  sgm_quo_t               quo_i,
  input  logic [OUT_SCALE_W-1:0] inv_scale_i,
  input  logic signed [7:0]      clamp_low_i,
  input  logic signed [7:0]      clamp_high_i,
  output logic                   out_valid_o,
  output sgm_out_t               out_data_o
);

  logic [OUT_STAGES-1:0] vld_q;
  logic [OUT_STAGES-1:0] last_q;
  logic [47:0]           o1_prod_q;
  logic [47:0]           o2_sum;
  logic [15:0]           o2_v_q;
  logic signed [16:0]    o3_v, o3_lo, o3_hi, o3_c;
  logic signed [7:0]     o3_act_q;

  assign o2_sum = o1_prod_q + (48'(1) << 31);

  always_comb begin
    o3_v  = signed'({1'b0, o2_v_q});
    o3_lo = 17'(clamp_low_i);
    o3_hi = 17'(clamp_high_i);
    o3_c  = (o3_v < o3_lo) ? o3_lo : o3_v;
    o3_c  = (o3_c > o3_hi) ? o3_hi : o3_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[OUT_STAGES-2:0], quo_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q    <= {last_q[OUT_STAGES-2:0], quo_i.tag.last};
      o1_prod_q <= 48'(quo_i.q) * 48'(inv_scale_i);
      o2_v_q    <= o2_sum[47:32];
      o3_act_q  <= o3_c[7:0];
    end
  end

  assign out_valid_o = vld_q[OUT_STAGES-1];
  assign out_data_o  = '{activation: o3_act_q, last_out: last_q[OUT_STAGES-1]};

endmodule

[design/quantized_sigmoid_int8_core.sv]
// Quantized int8 sigmoid core. Stages from input transfer to result:
// 7 exponent stages, 10 divider stages (setup plus 2 quotient bits per stage),
// 3 output stages. Throughput one item per cycle; the whole pipe holds when the
// output is stalled. Reset clears valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quantized_sigmoid_int8_core import sgm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sgm_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sgm_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [IN_SCALE_W-1:0]  in_scale_q;
  logic [OUT_SCALE_W-1:0] inv_scale_q;
  logic signed [7:0]      clamp_low_q, clamp_high_q;
  logic                   adv;
  sgm_exp_t               exp_s;
  sgm_quo_t               quo_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_scale_q   <= 24'd65536;
      inv_scale_q  <= 31'd16777216;
      clamp_low_q  <= -8'sd128;
      clamp_high_q <= 8'sd127;
    end else if (cfg_we_i) begin
      unique case (sgm_reg_e'(cfg_idx_i))
        REG_IN_SCALE:      in_scale_q   <= cfg_wdata_i[IN_SCALE_W-1:0];
        REG_INV_OUT_SCALE: inv_scale_q  <= cfg_wdata_i[OUT_SCALE_W-1:0];
        REG_CLAMP_LOW:     clamp_low_q  <= signed'(cfg_wdata_i[7:0]);
        REG_CLAMP_HIGH:    clamp_high_q <= signed'(cfg_wdata_i[7:0]);
      endcase
    end
  end

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  sgm_exp u_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_scale_i (in_scale_q),
    .exp_o      (exp_s)
  );

  sgm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .exp_i  (exp_s),
    .quo_o  (quo_s)
  );

  sgm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .quo_i        (quo_s),
    .inv_scale_i  (inv_scale_q),
    .clamp_low_i  (clamp_low_q),
    .clamp_high_i (clamp_high_q),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  `SGM_ASSERT_IMP(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  `SGM_ASSERT_IMP(a_exp_bounded, exp_s.valid, exp_s.e <= Q16_ONE)
  `SGM_ASSERT_IMP(a_pos_half_or_more, quo_s.valid && !quo_s.tag.neg, quo_s.q >= 17'd32768)
  `SGM_ASSERT_NEVER(a_neg_below_one, quo_s.valid && quo_s.tag.neg && quo_s.q >= Q16_ONE)

endmodule

[verif/tb_top.sv]
// Testbench for quantized_sigmoid_int8_core: random and directed int8 samples against a
// fixed-point sigmoid predictor, with bursty input, stalling output and register phases.
// Depends on sgm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import sgm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 30;

  typedef enum {RX_FULL, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sgm_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sgm_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers, reset values
  logic [IN_SCALE_W-1:0]  in_scale  = 24'd65536;
  logic [OUT_SCALE_W-1:0] inv_scale = 31'd16777216;
  logic signed [7:0]      lo_bound  = -8'sd128;
  logic signed [7:0]      hi_bound  = 8'sd127;

  sgm_in_t  pending[$];
  sgm_out_t act_q[$];
  int       errors = 0;
  logic     in_taken = 1'b0;
  bit       offering = 1'b0;
  bit       stall_req = 1'b0;

  quantized_sigmoid_int8_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // e^-a in Q16
  function automatic longint exp_neg_q16(longint a);
    longint t, k, f, f2, f3, p;
    if (a <= 0) return longint'(Q16_ONE);
    t = (a * longint'(INV_LN2_Q16)) >>> 16;
    k = t >>> 16;
    f = t & 64'hFFFF;
    if (k >= longint'(SHIFT_LIMIT)) return 0;
    f2 = (f * f) >>> 16;
    f3 = (f2 * f) >>> 16;
    p = longint'(Q16_ONE) - ((longint'(C1_Q16) * f) >>> 16)
        + ((longint'(C2_Q16) * f2) >>> 16) - ((longint'(C3_Q16) * f3) >>> 16);
    if (p < 0) p = 0;
    if (k > 0) p = (p + (longint'(1) << (k - 1))) >>> k;
    if (p > longint'(Q16_ONE)) p = longint'(Q16_ONE);
    return p;
  endfunction

  function automatic sgm_out_t sigmoid_predict(sgm_in_t item);
    longint   z, e, sig, v;
    sgm_out_t res;
    z = longint'(item.sample) * longint'(in_scale);
    if (z >= 0) begin
      e = exp_neg_q16(z);
      sig = (longint'(1) << 32) / (65536 + e);
    end else begin
      e = exp_neg_q16(-z);
      sig = (e * 65536) / (65536 + e);
    end
    v = (sig * longint'(inv_scale) + (longint'(1) << 31)) >>> 32;
    if (v < longint'(lo_bound)) v = longint'(lo_bound);
    if (v > longint'(hi_bound)) v = longint'(hi_bound);
    res.activation = v[7:0];
    res.last_out   = item.last_in;
    return res;
  endfunction

  // transfer tracking, scoreboard and register mirror
  always @(posedge clk) begin
    sgm_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) act_q.push_back(sigmoid_predict(in_data));
      if (out_valid && out_ready) begin
        if (act_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual activation=%0d last=%0b",
                   $time, out_data.activation, out_data.last_out);
          errors++;
        end else begin
          want = act_q.pop_front();
          if (out_data.activation !== want.activation) begin
            $display("%0t: activation expected %0d actual %0d", $time,
                     want.activation, out_data.activation);
            errors++;
          end
          if (out_data.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b actual %0b", $time,
                     want.last_out, out_data.last_out);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (sgm_reg_e'(cfg_idx))
          REG_IN_SCALE:      in_scale  <= cfg_wdata[IN_SCALE_W-1:0];
          REG_INV_OUT_SCALE: inv_scale <= cfg_wdata[OUT_SCALE_W-1:0];
          REG_CLAMP_LOW:     lo_bound  <= cfg_wdata[7:0];
          REG_CLAMP_HIGH:    hi_bound  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // input driver: bursts with random gaps
  always @(negedge clk) begin
    bit nv;
    int burst_left;
    int gap_left;
    nv = in_valid;
    if (in_valid && in_taken) nv = 1'b0;
    if (rst_n && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0) begin
        in_data <= pending.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 8);
        end
      end
    end
    offering = nv;
    in_valid <= nv;
  end

  // output receiver: own stall pattern plus one long hold-off on request
  always @(negedge clk) begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       hold_left;
    bit       stall_seen;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_req && !stall_seen) begin
        stall_seen = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FULL:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, act_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(sgm_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_bounds(logic signed [7:0] lo, logic signed [7:0] hi);
    cfg_write(REG_CLAMP_LOW, {{(CFG_DATA_W-8){lo[7]}}, lo});
    cfg_write(REG_CLAMP_HIGH, {{(CFG_DATA_W-8){hi[7]}}, hi});
  endtask

  task automatic queue_sample(logic signed [7:0] s, logic last);
    sgm_in_t item;
    item.sample  = s;
    item.last_in = last;
    pending.push_back(item);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || offering || act_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [IN_SCALE_W-1:0]  scale;
    logic [OUT_SCALE_W-1:0] inv;
    logic signed [7:0]      lo, hi;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, field extremes and zero input
    queue_sample(-8'sd128, 1'b0);
    queue_sample(-8'sd127, 1'b1);
    queue_sample(-8'sd64, 1'b0);
    queue_sample(-8'sd2, 1'b1);
    queue_sample(-8'sd1, 1'b0);
    queue_sample(8'sd0, 1'b1);
    queue_sample(8'sd1, 1'b0);
    queue_sample(8'sd2, 1'b1);
    queue_sample(8'sd64, 1'b0);
    queue_sample(8'sd126, 1'b0);
    queue_sample(8'sd127, 1'b1);
    wait_drained();

    // largest scales: shift saturates for big magnitudes
    cfg_write(REG_IN_SCALE, 31'hFFFFFF);
    cfg_write(REG_INV_OUT_SCALE, 31'h7FFFFFFF);
    queue_sample(-8'sd128, 1'b1);
    queue_sample(-8'sd1, 1'b0);
    queue_sample(8'sd0, 1'b0);
    queue_sample(8'sd1, 1'b1);
    queue_sample(8'sd127, 1'b0);
    wait_drained();

    // zero scale and crossed bounds
    cfg_write(REG_IN_SCALE, '0);
    cfg_write(REG_INV_OUT_SCALE, 31'd16777216);
    set_bounds(8'sd10, -8'sd10);
    queue_sample(-8'sd5, 1'b0);
    queue_sample(8'sd0, 1'b1);
    queue_sample(8'sd5, 1'b0);
    wait_drained();

    // zero output scale, equal bounds at the top
    cfg_write(REG_IN_SCALE, 31'd1);
    cfg_write(REG_INV_OUT_SCALE, '0);
    set_bounds(8'sd127, 8'sd127);
    queue_sample(-8'sd128, 1'b1);
    queue_sample(8'sd127, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0:       scale = '0;
        1:       scale = '1;
        2:       scale = IN_SCALE_W'($urandom_range(1, 1024));
        3:       scale = IN_SCALE_W'($urandom_range(1024, 262144));
        default: scale = IN_SCALE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       inv = '0;
        1:       inv = '1;
        2:       inv = OUT_SCALE_W'($urandom_range(1 << 22, 1 << 26));
        default: inv = OUT_SCALE_W'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) begin
        lo = -8'sd128;
        hi = 8'sd127;
      end else begin
        lo = 8'($urandom);
        hi = 8'($urandom);
      end
      cfg_write(REG_IN_SCALE, {7'($urandom), scale});
      cfg_write(REG_INV_OUT_SCALE, inv);
      set_bounds(lo, hi);
      if (ph == 3) stall_req = 1'b1;
      for (int n = 0; n < 54; n++) queue_sample(8'($urandom), $urandom_range(0, 7) == 0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && act_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
